[hw/rtl/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants and controller/datapath types for the sorted table search.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 30;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = 11;
    localparam int CNT_W       = 11;
    localparam int STATUS_W    = 2;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic                init_search;
        logic                mem_wr;
        logic                probe;
        logic                step;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } stbs_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
    } stbs_sts_t;

endpackage

[hw/rtl/stbs_if.sv]
// ----------------------------------------------------------------------------
// stbs_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface stbs_req_if
    import stbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] entry_index;

    modport source (output valid, output func, output key, output entry_index, input ready);
    modport sink   (input valid, input func, input key, input entry_index, output ready);
endinterface

interface stbs_rsp_if
    import stbs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;

    modport source (output valid, output status, output found_position, input ready);
    modport sink   (input valid, input status, input found_position, output ready);
endinterface

[hw/rtl/stbs_ctrl.sv]
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for load and search beats and the response valid flag.
// ----------------------------------------------------------------------------
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_func,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  stbs_sts_t sts,
    output stbs_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_PROBE  = 2'd1;
    localparam logic [1:0] S_CMP    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [STATUS_W-1:0] pend_reg, pend_next;
    logic                valid_reg, valid_next;
    logic                out_free;

    assign out_free  = !valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        cmd            = '0;
        cmd.out_status = pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_func == FUNC_SEARCH)
                    begin
                        cmd.init_search = 1'b1;
                        state_next      = S_PROBE;
                    end
                    else
                    begin
                        cmd.mem_wr = 1'b1;
                        pend_next  = ST_LOADED;
                        state_next = S_FINISH;
                    end
                end
            end
            S_PROBE:
            begin
                if (sts.empty)
                begin
                    pend_next  = ST_MISSING;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.hit)
                begin
                    pend_next  = ST_FOUND;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= ST_LOADED;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[hw/rtl/stbs_dpath.sv]
// ----------------------------------------------------------------------------
// stbs_dpath
// Key table, search bounds, probe compare and response payload register.
// ----------------------------------------------------------------------------
module stbs_dpath
    import stbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    input  logic [KEY_W-1:0]    req_key,
    input  logic [ADDR_W-1:0]   req_entry_index,
    input  stbs_cmd_t           cmd,
    output stbs_sts_t           sts,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [POS_W-1:0]    rsp_found_position
);

    logic [KEY_W-1:0]    key_table [TABLE_DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [POS_W-1:0]    lower_reg, upper_reg, mid_reg;
    logic [KEY_W-1:0]    key_reg, rd_data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    count_sat;
    logic [POS_W:0]      bound_sum;
    logic [POS_W-1:0]    mid;
    logic [POS_W-1:0]    mid_less;
    logic [ADDR_W-1:0]   rd_addr;

    assign count_sat = (count_reg > CNT_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                        : POS_W'(count_reg);
    assign bound_sum = {1'b0, lower_reg} + {1'b0, upper_reg};
    assign mid       = bound_sum[POS_W:1];
    assign mid_less  = mid - POS_W'(1);
    assign rd_addr   = mid_less[ADDR_W-1:0];

    assign sts.empty = (lower_reg > upper_reg);
    assign sts.hit   = (rd_data_reg == key_reg);

    assign rsp_status         = status_reg;
    assign rsp_found_position = pos_reg;

    // key table
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            key_table[req_entry_index] <= req_key;
        end
        if (cmd.probe)
        begin
            rd_data_reg <= key_table[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(TABLE_DEPTH);
            lower_reg <= POS_W'(1);
            upper_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (cmd.init_search)
            begin
                lower_reg <= POS_W'(1);
                upper_reg <= count_sat;
            end
            else if (cmd.step)
            begin
                if (rd_data_reg > key_reg)
                begin
                    upper_reg <= mid_reg - POS_W'(1);
                end
                else
                begin
                    lower_reg <= mid_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_search)
        begin
            key_reg <= req_key;
        end
        if (cmd.probe)
        begin
            mid_reg <= mid;
        end
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_status;
            pos_reg    <= (cmd.out_status == ST_FOUND) ? mid_reg : '0;
        end
    end

endmodule

[hw/rtl/sorted_table_binary_search.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a software-loaded ascending key table.
// ----------------------------------------------------------------------------
// One item is in work at a time. A load beat writes its slot at acceptance,
// then a finish state loads its response into the output register. A search
// runs through a probe state, which does the registered table read at the
// midpoint, and a compare state, which compares and updates the bounds, once
// per probe, then a finish state that waits until the output register is
// free; a miss takes one more probe state to see the bounds cross. At most
// eleven probes run over 1024 entries. The single read port of the key table
// sets the pace of a search. The response sits in an output register, so the
// next beat is taken while a response still waits.
module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    stbs_req_if.sink         req,
    stbs_rsp_if.source       rsp
);

    stbs_cmd_t cmd;
    stbs_sts_t sts;

    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    stbs_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .req_key            (req.key),
        .req_entry_index    (req.entry_index),
        .cmd                (cmd),
        .sts                (sts),
        .rsp_status         (rsp.status),
        .rsp_found_position (rsp.found_position)
    );

    // no response overwritten while still pending
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp.valid || rsp.ready))
        else $error("response overwritten");

    // every probe is followed by a compare cycle
    a_probe_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe |=> (!cmd.probe && !req.ready))
        else $error("probe not followed by compare");

    // a new beat is only taken with no search in flight
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> (!cmd.probe && !cmd.step && !cmd.out_load))
        else $error("beat accepted while busy");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the sorted table binary search. Loads key tables of several
// sizes, mostly sorted, plus unsorted and duplicate-key ones, runs hit, miss
// and edge searches under random back-pressure, and checks every response
// against an in-bench binary search over a mirror of the loaded table.
// ----------------------------------------------------------------------------
module tb;
    import stbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int SEARCHES_PER_PHASE = 24;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    found_position;
    } search_result_t;

    class search_scoreboard;
        logic [KEY_W-1:0] key_mirror [TABLE_DEPTH];
        logic [CNT_W-1:0] entry_count;
        search_result_t   expected_q [$];
        int               errors;

        function new();
            entry_count = CNT_W'(TABLE_DEPTH);
            errors = 0;
        endfunction

        function void set_entry_count(logic [CNT_W-1:0] value);
            entry_count = value;
        endfunction

        function search_result_t find_position(logic [KEY_W-1:0] target);
            search_result_t r;
            int lo;
            int hi;
            int mid;
            lo = 1;
            hi = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
            r.status = ST_MISSING;
            r.found_position = '0;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (key_mirror[mid - 1] > target)
                    hi = mid - 1;
                else if (key_mirror[mid - 1] < target)
                    lo = mid + 1;
                else
                begin
                    r.status = ST_FOUND;
                    r.found_position = POS_W'(mid);
                    break;
                end
            end
            return r;
        endfunction

        function void note_request(logic func, logic [KEY_W-1:0] key,
                                   logic [ADDR_W-1:0] entry_index);
            search_result_t r;
            if (func == FUNC_LOAD)
            begin
                key_mirror[entry_index] = key;
                r.status = ST_LOADED;
                r.found_position = '0;
            end
            else
                r = find_position(key);
            expected_q.push_back(r);
        endfunction

        function void check_response(logic [STATUS_W-1:0] status,
                                     logic [POS_W-1:0] found_position);
            search_result_t r;
            if (expected_q.size() == 0)
            begin
                $error("unexpected response beat: status %0d found_position %0d",
                       status, found_position);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (status !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, status);
                errors++;
            end
            if (found_position !== r.found_position)
            begin
                $error("found_position: expected %0d, actual %0d",
                       r.found_position, found_position);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    bit clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    stbs_req_if req_ch ();
    stbs_rsp_if rsp_ch ();

    search_scoreboard sb = new();

    int send_idle_pct = 26;
    int rcv_idle_pct = 86;
    int items_sent = 0;

    sorted_table_binary_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_item(logic func, logic [KEY_W-1:0] key,
                             logic [ADDR_W-1:0] entry_index);
        int gap;
        @(negedge clk);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.func = func;
        req_ch.key = key;
        req_ch.entry_index = entry_index;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
                break;
        end
        sb.note_request(func, key, entry_index);
        items_sent++;
        if (items_sent >= 900)
        begin
            send_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        else if (items_sent >= 450)
        begin
            send_idle_pct = 86;
            rcv_idle_pct = 26;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_entry_count(logic [CNT_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        sb.set_entry_count(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // response side: random stalls, check each beat
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = (rcv_idle_pct == 0) || ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.found_position);
    end

    // watchdog on cycles without any beat
    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("** sorted_table_binary_search: FAILED **");
        $finish;
    end

    initial
    begin
        int counts [10];
        bit written [TABLE_DEPTH];
        int n_eff;
        int pick;
        bit all_written;
        longint cur;
        longint span;
        logic [KEY_W-1:0] target;

        counts = '{2, 9, 1, 40, 1024, 2047, 1500, 300, 0, 17};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_LOAD;
        req_ch.key = '0;
        req_ch.entry_index = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty range, no probes
        write_entry_count('0);
        send_item(FUNC_SEARCH, '0, '0);
        send_item(FUNC_SEARCH, KEY_MAX, '0);

        send_item(FUNC_LOAD, '0, 10'd0);
        send_item(FUNC_LOAD, 30'd100, 10'd1);
        send_item(FUNC_LOAD, KEY_MAX, 10'd2);
        send_item(FUNC_LOAD, KEY_MAX, '1);

        write_entry_count(11'd1);
        send_item(FUNC_SEARCH, '0, '0);
        send_item(FUNC_SEARCH, 30'd5, '0);

        write_entry_count(11'd3);
        send_item(FUNC_SEARCH, '0, '0);
        send_item(FUNC_SEARCH, 30'd100, '0);
        send_item(FUNC_SEARCH, KEY_MAX, '0);
        send_item(FUNC_SEARCH, 30'd50, '1);
        send_item(FUNC_SEARCH, 30'd101, '0);

        // unsorted table
        send_item(FUNC_LOAD, KEY_MAX, 10'd0);
        send_item(FUNC_SEARCH, KEY_MAX, '0);
        send_item(FUNC_SEARCH, '0, '0);

        // duplicate keys
        send_item(FUNC_LOAD, 30'd7, 10'd0);
        send_item(FUNC_LOAD, 30'd7, 10'd1);
        send_item(FUNC_LOAD, 30'd7, 10'd2);
        send_item(FUNC_SEARCH, 30'd7, '0);

        for (int p = 0; p < 10; p++)
        begin
            write_entry_count(CNT_W'(counts[p]));
            n_eff = (counts[p] > TABLE_DEPTH) ? TABLE_DEPTH : counts[p];
            all_written = 1'b1;
            for (int i = 0; i < n_eff; i++)
                if (!written[i])
                    all_written = 1'b0;

            // fresh ascending table over the active range
            if (!all_written || n_eff <= 64)
            begin
                cur = $urandom_range(0, 255);
                for (int i = 0; i < n_eff; i++)
                begin
                    send_item(FUNC_LOAD, KEY_W'(cur), ADDR_W'(i));
                    written[i] = 1'b1;
                    span = (longint'(KEY_MAX) - cur) / (n_eff - i);
                    if (span > 0 && $urandom_range(0, 7) != 0)
                        cur += $urandom_range(1, int'(2 * span));
                    if (cur > longint'(KEY_MAX))
                        cur = longint'(KEY_MAX);
                end
            end

            for (int s = 0; s < SEARCHES_PER_PHASE; s++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                begin
                    target = KEY_W'($urandom());
                    n_eff = n_eff;
                    send_item(FUNC_LOAD, target, ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)));
                end
                else
                begin
                    if (n_eff > 0 && pick < 55)
                        target = sb.key_mirror[$urandom_range(0, n_eff - 1)];
                    else if (n_eff > 0 && pick < 75)
                        target = sb.key_mirror[$urandom_range(0, n_eff - 1)]
                                 + ($urandom_range(0, 1) ? KEY_W'(1) : KEY_MAX);
                    else if (pick < 88)
                        target = KEY_W'($urandom());
                    else
                        target = $urandom_range(0, 1) ? KEY_MAX : '0;
                    send_item(FUNC_SEARCH, target, ADDR_W'($urandom()));
                end
            end
        end

        drain();
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("** sorted_table_binary_search: PASSED **");
        else
            $display("** sorted_table_binary_search: FAILED **");
        $finish;
    end

endmodule
